@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Each expects clk in scope; SPFE_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SPFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPFE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPFE_ASSERT(lbl, prop, msg)
`define SPFE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/spfe_pkg.sv @@
package spfe_pkg;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] match_position;
        logic [31:0] frame_number;
        logic [63:0] field_value;
        logic        last_result;
    } result_t;

    // Result kinds
    localparam logic [1:0] KIND_FIELD = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_OVER  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_PATTERN  = 3'd0;
    localparam logic [2:0] REG_PLEN     = 3'd1;
    localparam logic [2:0] REG_DISTANCE = 3'd2;
    localparam logic [2:0] REG_FLEN     = 3'd3;
    localparam logic [2:0] REG_BEFORE   = 3'd4;
    localparam logic [2:0] REG_BIG      = 3'd5;

    // Register reset values (default pattern A5 BE)
    localparam logic [63:0] RST_PATTERN  = 64'h0000_0000_0000_A5BE;
    localparam logic [3:0]  RST_PLEN     = 4'd2;
    localparam logic [7:0]  RST_DISTANCE = 8'd5;
    localparam logic [3:0]  RST_FLEN     = 4'd2;

    // Configuration as seen by the classifier
    typedef struct packed {
        logic [3:0] plen;
        logic [3:0] flen;
        logic [7:0] distance;
        logic       field_before;
    } cfg_t;

    // Classification of a match against the current byte
    typedef enum logic [1:0] {
        CLS_FIELD = 2'd0,
        CLS_RANGE = 2'd1,
        CLS_WAIT  = 2'd2
    } cls_t;

endpackage

@@ rtl/spfe_ram.sv @@
module spfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/spfe_classify.sv @@
module spfe_classify #(
    parameter int HISTORY_DEPTH = 512
) (
    input  logic [31:0]                  pos,
    input  logic [31:0]                  cur,
    input  spfe_pkg::cfg_t               cfg,
    output spfe_pkg::cls_t               code,
    output logic [$clog2(HISTORY_DEPTH)-1:0] diff
);
    import spfe_pkg::*;

    localparam int HAW = $clog2(HISTORY_DEPTH);

    logic [33:0] start;
    logic [33:0] last_byte;
    logic [33:0] age;
    logic        before_zero;

    // Field start, its last byte and its age against the current byte
    always_comb
    begin
        before_zero = cfg.field_before && (pos < {24'd0, cfg.distance});
        if (cfg.field_before)
        begin
            start = {2'b00, pos} - {26'd0, cfg.distance};
        end
        else
        begin
            start = {2'b00, pos} + {30'd0, cfg.plen} + {26'd0, cfg.distance};
        end
        last_byte = start + {30'd0, cfg.flen} - 34'd1;
        age       = {2'b00, cur} - start;
        diff      = age[HAW-1:0];
        if (before_zero)
        begin
            code = CLS_RANGE;
        end
        else if (last_byte > {2'b00, cur})
        begin
            code = CLS_WAIT;
        end
        else if (age >= 34'(HISTORY_DEPTH))
        begin
            code = CLS_RANGE;
        end
        else
        begin
            code = CLS_FIELD;
        end
    end

endmodule

@@ rtl/sync_pattern_field_extractor.sv @@
// Sync pattern detector with field extraction. Bytes enter one at a time and
// each item is worked through by a small sequencer before the next is taken.
// For each byte it checks every waiting match, fetches the field bytes (up to
// MAX_FIELD_BYTES) for every extraction, flushes the waiting matches at end of
// stream, makes the done check and hands out each result item, waiting while
// the output is stalled. Its pace is set by the single read port of the
// history memory and of the pending match queue, both read one entry at a
// time. Results of one byte leave in order; the final one carries last_result.
// No clearing pass is needed after reset.
`include "assert_macros.svh"
module sync_pattern_field_extractor #(
    parameter int HISTORY_DEPTH     = 512,
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int MAX_FIELD_BYTES   = 8,
    parameter int PENDING_DEPTH     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  spfe_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output spfe_pkg::result_t   out_data
);
    import spfe_pkg::*;

    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int PAW = PENDING_DEPTH > 1 ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW  = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_PREAD = 10'b00_0000_0010,
        S_PWAIT = 10'b00_0000_0100,
        S_FRD   = 10'b00_0000_1000,
        S_FDAT  = 10'b00_0001_0000,
        S_PUSH  = 10'b00_0010_0000,
        S_MATCH = 10'b00_0100_0000,
        S_EREAD = 10'b00_1000_0000,
        S_EWAIT = 10'b01_0000_0000,
        S_FLUSH = 10'b10_0000_0000
    } state_t;

    // Configuration registers
    logic [63:0] pattern_reg;
    logic [3:0]  plen_cfg_reg;
    logic [7:0]  distance_reg;
    logic [3:0]  flen_cfg_reg;
    logic        before_reg;
    logic        big_reg;

    // Stream state
    state_t          state_reg, state_next, ret_reg, ret_next;
    logic [63:0]     window_reg, window_next;
    logic [31:0]     index_reg, index_next;
    logic [HAW-1:0]  ring_reg, ring_next;
    logic [31:0]     allowed_reg, allowed_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     frames_reg, frames_next;
    // Per item working registers
    logic [31:0]     cur_reg, cur_next;
    logic [HAW-1:0]  cur_addr_reg, cur_addr_next;
    logic            eos_reg, eos_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   keep_reg, keep_next;
    logic [31:0]     pos_reg, pos_next;
    logic [HAW-1:0]  faddr_reg, faddr_next;
    logic [2:0]      k_reg, k_next;
    logic [63:0]     value_reg, value_next;
    result_t         new_reg, new_next;
    result_t         hold_reg, hold_next;
    logic            hold_v_reg, hold_v_next;
    result_t         out_reg, out_next;
    logic            out_v_reg, out_v_next;

    logic [3:0]      plen;
    logic [3:0]      flen;
    cfg_t            cfg;
    logic            accept;
    logic            out_free;
    logic [31:0]     cls_pos;
    cls_t            cls_code;
    logic [HAW-1:0]  cls_diff;
    logic [HAW:0]    start_addr;
    logic [63:0]     mask;
    logic [32:0]     cur_plus;
    logic [31:0]     match_pos;
    logic            match_hit;
    logic            little;
    logic [63:0]     value_step;
    logic            hist_we;
    logic [HAW-1:0]  hist_raddr;
    logic [7:0]      hist_rdata;
    logic            pend_we;
    logic [PAW-1:0]  pend_waddr;
    logic [31:0]     pend_wdata;
    logic [PAW-1:0]  pend_raddr;
    logic [31:0]     pend_rdata;

    // Effective lengths
    always_comb
    begin
        if (plen_cfg_reg == 4'd0)
            plen = 4'd1;
        else if (plen_cfg_reg > 4'(MAX_PATTERN_BYTES))
            plen = 4'(MAX_PATTERN_BYTES);
        else
            plen = plen_cfg_reg;
        if (flen_cfg_reg == 4'd0)
            flen = 4'd1;
        else if (flen_cfg_reg > 4'(MAX_FIELD_BYTES))
            flen = 4'(MAX_FIELD_BYTES);
        else
            flen = flen_cfg_reg;
    end

    assign cfg = '{plen: plen, flen: flen, distance: distance_reg, field_before: before_reg};

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_v_reg || !out_stall;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= RST_PATTERN;
            plen_cfg_reg <= RST_PLEN;
            distance_reg <= RST_DISTANCE;
            flen_cfg_reg <= RST_FLEN;
            before_reg   <= 1'b1;
            big_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN:  pattern_reg  <= cfg_data;
                REG_PLEN:     plen_cfg_reg <= cfg_data[3:0];
                REG_DISTANCE: distance_reg <= cfg_data[7:0];
                REG_FLEN:     flen_cfg_reg <= cfg_data[3:0];
                REG_BEFORE:   before_reg   <= cfg_data[0];
                REG_BIG:      big_reg      <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Shared classifier: waiting match or the new match
    assign cls_pos = (state_reg == S_PWAIT) ? pend_rdata : match_pos;

    spfe_classify #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_classify (
        .pos  (cls_pos),
        .cur  (cur_reg),
        .cfg  (cfg),
        .code (cls_code),
        .diff (cls_diff)
    );

    // Ring address of the field's first byte
    always_comb
    begin
        if (cur_addr_reg >= cls_diff)
            start_addr = {1'b0, cur_addr_reg} - {1'b0, cls_diff};
        else
            start_addr = {1'b0, cur_addr_reg} + (HAW+1)'(HISTORY_DEPTH) - {1'b0, cls_diff};
    end

    // Pattern compare on the last plen bytes
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            mask[8*j +: 8] = (j < int'(plen)) ? 8'hFF : 8'h00;
        end
        cur_plus  = {1'b0, cur_reg} + 33'd1;
        match_pos = 32'(cur_plus - {29'd0, plen});
        match_hit = (cur_plus >= {29'd0, plen})
                    && ((window_reg & mask) == (pattern_reg & mask))
                    && (match_pos >= allowed_reg);
    end

    // Field byte assembly
    assign little = !big_reg && (flen == 4'd2 || flen == 4'd4);
    assign value_step = little ? (value_reg | ({56'd0, hist_rdata} << {k_reg, 3'b000}))
                               : {value_reg[55:0], hist_rdata};

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        window_next   = window_reg;
        index_next    = index_reg;
        ring_next     = ring_reg;
        allowed_next  = allowed_reg;
        count_next    = count_reg;
        frames_next   = frames_reg;
        cur_next      = cur_reg;
        cur_addr_next = cur_addr_reg;
        eos_next      = eos_reg;
        i_next        = i_reg;
        keep_next     = keep_reg;
        pos_next      = pos_reg;
        faddr_next    = faddr_reg;
        k_next        = k_reg;
        value_next    = value_reg;
        new_next      = new_reg;
        hold_next     = hold_reg;
        hold_v_next   = hold_v_reg;
        out_next      = out_reg;
        out_v_next    = out_v_reg && out_stall;
        hist_we       = 1'b0;
        hist_raddr    = faddr_reg;
        pend_we       = 1'b0;
        pend_waddr    = keep_reg[PAW-1:0];
        pend_wdata    = pend_rdata;
        pend_raddr    = i_reg[PAW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hist_we       = 1'b1;
                    window_next   = {window_reg[55:0], in_data.data_byte};
                    cur_next      = index_reg;
                    cur_addr_next = ring_reg;
                    eos_next      = in_data.end_of_stream;
                    index_next    = index_reg + 32'd1;
                    if (index_next == 32'd0)
                        ring_next = '0;
                    else if (ring_reg == HAW'(HISTORY_DEPTH - 1))
                        ring_next = '0;
                    else
                        ring_next = ring_reg + HAW'(1);
                    i_next     = '0;
                    keep_next  = '0;
                    state_next = S_PREAD;
                end
            end
            // Walk the waiting matches
            S_PREAD:
            begin
                if (i_reg < count_reg)
                begin
                    state_next = S_PWAIT;
                end
                else
                begin
                    count_next = keep_reg;
                    state_next = S_MATCH;
                end
            end
            S_PWAIT:
            begin
                i_next   = i_reg + CW'(1);
                pos_next = pend_rdata;
                ret_next = S_PREAD;
                case (cls_code)
                    CLS_WAIT:
                    begin
                        pend_we    = 1'b1;
                        keep_next  = keep_reg + CW'(1);
                        state_next = S_PREAD;
                    end
                    CLS_FIELD:
                    begin
                        faddr_next = start_addr[HAW-1:0];
                        k_next     = '0;
                        value_next = '0;
                        state_next = S_FRD;
                    end
                    default:
                    begin
                        new_next   = '{KIND_RANGE, pend_rdata, frames_reg, 64'd0, 1'b0};
                        state_next = S_PUSH;
                    end
                endcase
            end
            // New match ending at this byte
            S_MATCH:
            begin
                i_next     = '0;
                pos_next   = match_pos;
                ret_next   = S_EREAD;
                state_next = S_EREAD;
                if (match_hit)
                begin
                    allowed_next = match_pos + {28'd0, plen};
                    case (cls_code)
                        CLS_WAIT:
                        begin
                            if (count_reg < CW'(PENDING_DEPTH))
                            begin
                                pend_we    = 1'b1;
                                pend_waddr = count_reg[PAW-1:0];
                                pend_wdata = match_pos;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                new_next   = '{KIND_OVER, match_pos, frames_reg, 64'd0, 1'b0};
                                state_next = S_PUSH;
                            end
                        end
                        CLS_FIELD:
                        begin
                            faddr_next = start_addr[HAW-1:0];
                            k_next     = '0;
                            value_next = '0;
                            state_next = S_FRD;
                        end
                        default:
                        begin
                            new_next   = '{KIND_RANGE, match_pos, frames_reg, 64'd0, 1'b0};
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end
            // Field fetch: S_FRD reads a history byte, S_FDAT adds it to the value
            S_FRD:
            begin
                hist_raddr = faddr_reg;
                if (faddr_reg == HAW'(HISTORY_DEPTH - 1))
                    faddr_next = '0;
                else
                    faddr_next = faddr_reg + HAW'(1);
                state_next = S_FDAT;
            end
            S_FDAT:
            begin
                value_next = value_step;
                k_next     = k_reg + 3'd1;
                if ({1'b0, k_reg} == flen - 4'd1)
                begin
                    frames_next = frames_reg + 32'd1;
                    new_next    = '{KIND_FIELD, pos_reg, frames_next, value_step, 1'b0};
                    state_next  = S_PUSH;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            // Hand a result to the hold stage, moving the older one out
            S_PUSH:
            begin
                if (!hold_v_reg)
                begin
                    hold_next   = new_reg;
                    hold_v_next = 1'b1;
                    state_next  = ret_reg;
                end
                else if (out_free)
                begin
                    out_next    = hold_reg;
                    out_v_next  = 1'b1;
                    hold_next   = new_reg;
                    state_next  = ret_reg;
                end
            end
            // End of stream: flush waiting matches, then done; otherwise go to S_FLUSH
            S_EREAD:
            begin
                if (!eos_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (i_reg < count_reg)
                begin
                    state_next = S_EWAIT;
                end
                else
                begin
                    new_next     = '{KIND_DONE, 32'd0, frames_reg, 64'd0, 1'b0};
                    window_next  = '0;
                    index_next   = '0;
                    ring_next    = '0;
                    allowed_next = '0;
                    count_next   = '0;
                    frames_next  = '0;
                    ret_next     = S_FLUSH;
                    state_next   = S_PUSH;
                end
            end
            S_EWAIT:
            begin
                i_next     = i_reg + CW'(1);
                new_next   = '{KIND_RANGE, pend_rdata, frames_reg, 64'd0, 1'b0};
                ret_next   = S_EREAD;
                state_next = S_PUSH;
            end
            // Final result of this item leaves with last_result set
            S_FLUSH:
            begin
                if (!hold_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next             = hold_reg;
                    out_next.last_result = 1'b1;
                    out_v_next           = 1'b1;
                    hold_v_next          = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            window_reg  <= '0;
            index_reg   <= '0;
            ring_reg    <= '0;
            allowed_reg <= '0;
            count_reg   <= '0;
            frames_reg  <= '0;
            eos_reg     <= 1'b0;
            i_reg       <= '0;
            keep_reg    <= '0;
            k_reg       <= '0;
            hold_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            window_reg  <= window_next;
            index_reg   <= index_next;
            ring_reg    <= ring_next;
            allowed_reg <= allowed_next;
            count_reg   <= count_next;
            frames_reg  <= frames_next;
            eos_reg     <= eos_next;
            i_reg       <= i_next;
            keep_reg    <= keep_next;
            k_reg       <= k_next;
            hold_v_reg  <= hold_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        cur_addr_reg <= cur_addr_next;
        pos_reg      <= pos_next;
        faddr_reg    <= faddr_next;
        value_reg    <= value_next;
        new_reg      <= new_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
    end

    // History of recent bytes
    spfe_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ring_reg),
        .wdata (in_data.data_byte),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Matches waiting for their field
    spfe_ram #(
        .WIDTH(32),
        .DEPTH(PENDING_DEPTH)
    ) u_pending (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    `SPFE_ASSERT(a_count_bound, count_reg <= CW'(PENDING_DEPTH), "pending count overflow")
    `SPFE_ASSERT(a_idle_hold_empty, accept |-> !hold_v_reg, "item taken with result held")
    `SPFE_ASSERT(a_fetch_bound, state_reg == S_FDAT |-> {1'b0, k_reg} < flen, "fetch overrun")
    `SPFE_ASSERT(a_keep_le_i, state_reg == S_PREAD |-> keep_reg <= i_reg, "queue compaction slip")

endmodule
